FILE: sv/drs_pkg.sv
`default_nettype none

package drs_pkg;

   // input actions
   localparam logic [2:0] ACT_TICK   = 3'd0;
   localparam logic [2:0] ACT_START  = 3'd1;
   localparam logic [2:0] ACT_STOP   = 3'd2;
   localparam logic [2:0] ACT_TOGGLE = 3'd3;
   localparam logic [2:0] ACT_MODE   = 3'd4;

   // key modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_MUTE = 2'd1;
   localparam logic [1:0] MODE_SOLO = 2'd2;

   // MIDI message constants
   localparam logic [7:0] NOTE_ON   = 8'h90;
   localparam logic [7:0] NOTE_OFF  = 8'h80;
   localparam logic [6:0] OFF_VALUE = 7'd127;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] cell_req;
      logic [2:0] key_index;
      logic [6:0] velocity;
      logic [1:0] key_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] note_key;
      logic [6:0] note_value;
      logic       last;
   } rsp_type;

   // decoded command, front to back
   typedef struct packed {
      logic [2:0] op;
      logic [7:0] step_idx;
      logic [2:0] slot;
      logic [6:0] velocity;
      logic [1:0] mode;
   } cmd_type;

   typedef struct packed {
      logic [3:0] midi_channel;
      logic [6:0] base_key;
      logic [7:0] hold_steps;
      logic [2:0] pages_in_use;
   } cfg_type;

endpackage

`default_nettype wire

FILE: sv/drum_step_sequencer.sv
// Channel  Dir  Handshake          Beat
// req      in   req_valid/ready    drs_pkg::req_type: action, cell, key, velocity, mode
// rsp      out  rsp_valid/ready    drs_pkg::rsp_type: one MIDI message, last on tick end
// csr      in   psel/penable APB   midi_channel, base_key, hold_steps, pages_in_use
//
// A tick reads the step's row, latches the play and release masks (ST_PREP), then walks
// the key slots once for note-on/off (ST_NOTE) and once more for releases (ST_REL),
// one slot per cycle unless a message waits on a stalled rsp; a retriggered key sends
// its note-off first. A toggle reads, then writes the row; start, stop, mode act in idle.
// Synchronous reset clears modes, hold state, the step and the per-row valid bits of
// the pattern; velocities are never cleared. A stalled rsp holds the sequencer; the
// front register and the two-beat queue keep taking req beats until they fill.
`default_nettype none

module drum_step_sequencer #(
   parameter int STEPS_PER_PAGE = 64,
   parameter int MAX_PAGES      = 4,
   parameter int KEY_SLOTS      = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  drs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output drs_pkg::rsp_type  rsp_data,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire  [3:0]        paddr,
   input  wire  [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import drs_pkg::*;

   localparam int TOTAL_STEPS = STEPS_PER_PAGE * MAX_PAGES;

   // register indexes (byte address / 4)
   localparam logic [1:0] CSR_MIDI_CHANNEL = 2'd0;
   localparam logic [1:0] CSR_BASE_KEY     = 2'd1;
   localparam logic [1:0] CSR_HOLD_STEPS   = 2'd2;
   localparam logic [1:0] CSR_PAGES        = 2'd3;

   logic [3:0] midi_channel_ff, midi_channel_in;
   logic [6:0] base_key_ff, base_key_in;
   logic [7:0] hold_steps_ff, hold_steps_in;
   logic [2:0] pages_ff, pages_in;
   logic       csr_wr;
   cfg_type    cfg;

   cmd_type    front_cmd, queue_cmd;
   logic       front_valid, front_ready;
   logic       queue_valid, queue_ready;

   // config port: write lands on the access cycle
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      midi_channel_in = midi_channel_ff;
      base_key_in     = base_key_ff;
      hold_steps_in   = hold_steps_ff;
      pages_in        = pages_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            CSR_MIDI_CHANNEL: midi_channel_in = pwdata[3:0];
            CSR_BASE_KEY:     base_key_in     = pwdata[6:0];
            CSR_HOLD_STEPS:   hold_steps_in   = pwdata[7:0];
            CSR_PAGES:        pages_in        = pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_MIDI_CHANNEL: prdata = {28'd0, midi_channel_ff};
         CSR_BASE_KEY:     prdata = {25'd0, base_key_ff};
         CSR_HOLD_STEPS:   prdata = {24'd0, hold_steps_ff};
         CSR_PAGES:        prdata = {29'd0, pages_ff};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         midi_channel_ff <= 4'd0;
         base_key_ff     <= 7'd36;
         hold_steps_ff   <= 8'd1;
         pages_ff        <= 3'd1;
      end else begin
         midi_channel_ff <= midi_channel_in;
         base_key_ff     <= base_key_in;
         hold_steps_ff   <= hold_steps_in;
         pages_ff        <= pages_in;
      end
   end

   always_comb begin
      cfg.midi_channel = midi_channel_ff;
      cfg.base_key     = base_key_ff;
      cfg.hold_steps   = hold_steps_ff;
      cfg.pages_in_use = pages_ff;
   end

   // front: decode and drop malformed beats
   drs_front #(
      .TOTAL_STEPS (TOTAL_STEPS),
      .KEY_SLOTS   (KEY_SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd_data  (front_cmd)
   );

   drs_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   // back: pattern store, key state and message sequencer
   drs_back #(
      .STEPS_PER_PAGE (STEPS_PER_PAGE),
      .MAX_PAGES      (MAX_PAGES),
      .KEY_SLOTS      (KEY_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd_data  (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // only note-on and note-off status bytes leave the block
   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.status_byte & 8'hF0) == NOTE_ON) ||
                    ((rsp_data.status_byte & 8'hF0) == NOTE_OFF))
      else $error("status byte is neither note-on nor note-off");

   // note-off always carries full value
   a_off_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_data.status_byte & 8'hF0) == NOTE_OFF))
         |-> (rsp_data.note_value == OFF_VALUE))
      else $error("note-off with wrong value");

   // channel nibble follows the configured channel
   a_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status_byte[3:0] == midi_channel_ff))
      else $error("status byte channel mismatch");

   // a hold_steps write is visible on the next cycle
   a_hold_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && (paddr[3:2] == CSR_HOLD_STEPS)) |=> (hold_steps_ff == $past(pwdata[7:0])))
      else $error("hold_steps write lost");

endmodule

`default_nettype wire

FILE: sv/drs_front.sv
`default_nettype none

module drs_front #(
   parameter int TOTAL_STEPS = 256,
   parameter int KEY_SLOTS   = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  drs_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  wire               cmd_ready,
   output drs_pkg::cmd_type  cmd_data
);
   import drs_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    keep;
   logic    accept;

   // classify; bad slots, cells, modes and actions are dropped here
   always_comb begin
      keep = 1'b0;
      case (req_data.action)
         ACT_TICK, ACT_START, ACT_STOP: begin
            keep = 1'b1;
         end
         ACT_TOGGLE: begin
            keep = (int'(req_data.cell_req) < TOTAL_STEPS) &&
                   (int'(req_data.key_index) < KEY_SLOTS);
         end
         ACT_MODE: begin
            keep = (int'(req_data.key_index) < KEY_SLOTS) &&
                   (req_data.key_mode inside {MODE_NONE, MODE_MUTE, MODE_SOLO});
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd_in.op       = req_data.action;
      cmd_in.step_idx = req_data.cell_req;
      cmd_in.slot     = req_data.key_index;
      cmd_in.velocity = req_data.velocity;
      cmd_in.mode     = req_data.key_mode;
      if (accept) begin
         valid_in = keep;
      end else begin
         valid_in = valid_ff && !cmd_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

endmodule

`default_nettype wire

FILE: sv/drs_fifo.sv
`default_nettype none

module drs_fifo (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   output logic              push_ready,
   input  drs_pkg::cmd_type  push_data,
   output logic              pop_valid,
   input  wire               pop_ready,
   output drs_pkg::cmd_type  pop_data
);
   import drs_pkg::*;

   // two-entry command queue
   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/drs_back.sv
`default_nettype none

module drs_back #(
   parameter int STEPS_PER_PAGE = 64,
   parameter int MAX_PAGES      = 4,
   parameter int KEY_SLOTS      = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  drs_pkg::cfg_type  cfg,
   input  wire               cmd_valid,
   output logic              cmd_ready,
   input  drs_pkg::cmd_type  cmd_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output drs_pkg::rsp_type  rsp_data
);
   import drs_pkg::*;

   localparam int TOTAL_STEPS = STEPS_PER_PAGE * MAX_PAGES;
   localparam int STEP_W      = $clog2(TOTAL_STEPS);
   localparam int LIM_W       = $clog2(TOTAL_STEPS + 1);
   localparam int PG_W        = $clog2(MAX_PAGES + 1);
   localparam int KEY_W       = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(KEY_SLOTS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TOG_WR = 3'd1;
   localparam logic [2:0] ST_PREP   = 3'd2;
   localparam logic [2:0] ST_NOTE   = 3'd3;
   localparam logic [2:0] ST_REL    = 3'd4;

   // pattern store: present rows with per-row valid, velocity lanes
   logic [KEY_SLOTS-1:0]      pres_mem [TOTAL_STEPS];
   logic [KEY_SLOTS-1:0][6:0] vel_mem  [TOTAL_STEPS];
   logic [TOTAL_STEPS-1:0]    row_valid_ff;
   logic [KEY_SLOTS-1:0]      pres_rd_ff;
   logic [KEY_SLOTS-1:0][6:0] vel_rd_ff;
   logic                      valid_rd_ff;

   logic                 rd_en;
   logic [STEP_W-1:0]    rd_addr;
   logic                 pres_we;
   logic                 vel_we;
   logic [STEP_W-1:0]    wr_addr;
   logic [KEY_SLOTS-1:0] pres_wdata;
   logic [KEY_W-1:0]     wr_slot;

   // sequencer state
   logic [2:0]           state_ff, state_in;
   logic [KEY_W-1:0]     k_ff, k_in;
   logic                 off_done_ff, off_done_in;
   logic                 playing_ff, playing_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [1:0]           mode_ff [KEY_SLOTS];
   logic [1:0]           mode_in [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] seen_ff, seen_in;
   logic [KEY_SLOTS-1:0] held_ff, held_in;
   logic [7:0]           count_ff [KEY_SLOTS];
   logic [7:0]           count_in [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] play_mask_ff, play_mask_in;
   logic [KEY_SLOTS-1:0] rel_mask_ff, rel_mask_in;
   cmd_type              tog_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [KEY_SLOTS-1:0] row_now;
   logic [KEY_SLOTS-1:0] play_c, rel_c;
   logic                 any_solo;
   logic                 emit;
   logic                 out_free;
   logic [KEY_W-1:0]     tog_slot;
   logic [PG_W-1:0]      pages_sat;
   logic [LIM_W-1:0]     limit;
   logic [LIM_W-1:0]     step_inc;
   logic [STEP_W-1:0]    step_wrap;
   logic [7:0]           stat_on, stat_off;

   function automatic logic above(input logic [KEY_SLOTS-1:0] m,
                                  input logic [KEY_W-1:0] k);
      logic r;
      r = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if ((j > int'(k)) && m[j]) begin
            r = 1'b1;
         end
      end
      return r;
   endfunction

   assign row_now  = valid_rd_ff ? pres_rd_ff : '0;
   assign tog_slot = tog_ff.slot[KEY_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign stat_on  = NOTE_ON + 8'(cfg.midi_channel);
   assign stat_off = NOTE_OFF + 8'(cfg.midi_channel);

   // who plays this tick and who gets released after it
   always_comb begin
      any_solo = 1'b0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
         if (mode_ff[k] == MODE_SOLO) begin
            any_solo = 1'b1;
         end
      end
      for (int k = 0; k < KEY_SLOTS; k++) begin
         play_c[k] = row_now[k] &&
                     (any_solo ? (mode_ff[k] == MODE_SOLO) : (mode_ff[k] == MODE_NONE));
         rel_c[k]  = (held_ff[k] || play_c[k]) &&
                     ((play_c[k] ? 8'd0 : count_ff[k]) >= cfg.hold_steps);
      end
   end

   // step wrap over the active pages
   always_comb begin
      if (int'(cfg.pages_in_use) > MAX_PAGES) begin
         pages_sat = PG_W'(MAX_PAGES);
      end else begin
         pages_sat = PG_W'(cfg.pages_in_use);
      end
      limit     = LIM_W'(pages_sat) * LIM_W'(STEPS_PER_PAGE);
      step_inc  = LIM_W'(step_ff) + LIM_W'(1);
      step_wrap = (step_inc >= limit) ? '0 : STEP_W'(step_inc);
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      off_done_in  = off_done_ff;
      playing_in   = playing_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      seen_in      = seen_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      play_mask_in = play_mask_ff;
      rel_mask_in  = rel_mask_ff;
      cmd_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = step_ff;
      pres_we      = 1'b0;
      vel_we       = 1'b0;
      wr_addr      = STEP_W'(tog_ff.step_idx);
      wr_slot      = tog_slot;
      pres_wdata   = row_now ^ (KEY_SLOTS'(1) << tog_slot);
      emit         = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               case (cmd_data.op)
                  ACT_TICK: begin
                     if (playing_ff) begin
                        rd_en    = 1'b1;
                        state_in = ST_PREP;
                     end
                  end
                  ACT_START: begin
                     playing_in = 1'b1;
                     step_in    = '0;
                  end
                  ACT_STOP: begin
                     playing_in = 1'b0;
                  end
                  ACT_TOGGLE: begin
                     rd_en    = 1'b1;
                     rd_addr  = STEP_W'(cmd_data.step_idx);
                     state_in = ST_TOG_WR;
                  end
                  ACT_MODE: begin
                     mode_in[cmd_data.slot[KEY_W-1:0]] = cmd_data.mode;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TOG_WR: begin
            // flip the bit; a new note also stores its velocity
            pres_we  = 1'b1;
            vel_we   = !row_now[tog_slot];
            state_in = ST_IDLE;
         end
         ST_PREP: begin
            play_mask_in = play_c;
            rel_mask_in  = rel_c;
            k_in         = '0;
            off_done_in  = 1'b0;
            state_in     = ST_NOTE;
         end
         ST_NOTE: begin
            if (!play_mask_ff[k_ff]) begin
               k_in = k_ff + KEY_W'(1);
               if (k_ff == LAST_KEY) begin
                  k_in     = '0;
                  state_in = ST_REL;
               end
            end else if (seen_ff[k_ff] && !off_done_ff) begin
               if (out_free) begin
                  emit               = 1'b1;
                  rsp_in.status_byte = stat_off;
                  rsp_in.note_key    = cfg.base_key + 7'(k_ff);
                  rsp_in.note_value  = OFF_VALUE;
                  rsp_in.last        = 1'b0;
                  off_done_in        = 1'b1;
               end
            end else if (out_free) begin
               emit               = 1'b1;
               rsp_in.status_byte = stat_on;
               rsp_in.note_key    = cfg.base_key + 7'(k_ff);
               rsp_in.note_value  = vel_rd_ff[k_ff];
               rsp_in.last        = (rel_mask_ff == '0) && !above(play_mask_ff, k_ff);
               seen_in[k_ff]      = 1'b1;
               held_in[k_ff]      = 1'b1;
               count_in[k_ff]     = 8'd0;
               off_done_in        = 1'b0;
               k_in               = k_ff + KEY_W'(1);
               if (k_ff == LAST_KEY) begin
                  k_in     = '0;
                  state_in = ST_REL;
               end
            end
         end
         ST_REL: begin
            if (!rel_mask_ff[k_ff] || out_free) begin
               if (rel_mask_ff[k_ff]) begin
                  emit               = 1'b1;
                  rsp_in.status_byte = stat_off;
                  rsp_in.note_key    = cfg.base_key + 7'(k_ff);
                  rsp_in.note_value  = OFF_VALUE;
                  rsp_in.last        = !above(rel_mask_ff, k_ff);
                  held_in[k_ff]      = 1'b0;
               end else if (held_ff[k_ff]) begin
                  count_in[k_ff] = count_ff[k_ff] + 8'd1;
               end
               k_in = k_ff + KEY_W'(1);
               if (k_ff == LAST_KEY) begin
                  k_in     = '0;
                  step_in  = step_wrap;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         off_done_ff  <= 1'b0;
         playing_ff   <= 1'b0;
         step_ff      <= '0;
         seen_ff      <= '0;
         held_ff      <= '0;
         play_mask_ff <= '0;
         rel_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         for (int k = 0; k < KEY_SLOTS; k++) begin
            mode_ff[k]  <= MODE_NONE;
            count_ff[k] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         off_done_ff  <= off_done_in;
         playing_ff   <= playing_in;
         step_ff      <= step_in;
         seen_ff      <= seen_in;
         held_ff      <= held_in;
         play_mask_ff <= play_mask_in;
         rel_mask_ff  <= rel_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         if (pres_we) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
      if (cmd_valid && cmd_ready) begin
         tog_ff <= cmd_data;
      end
   end

   // pattern memories
   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[wr_addr] <= pres_wdata;
      end
      if (vel_we) begin
         vel_mem[wr_addr][wr_slot] <= tog_ff.velocity;
      end
      if (rd_en) begin
         pres_rd_ff  <= pres_mem[rd_addr];
         vel_rd_ff   <= vel_mem[rd_addr];
         valid_rd_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: tb/sv/drum_step_sequencer_tb.sv
module drum_step_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import drs_pkg::*;

   // Block geometry, matches the DUT defaults
   localparam int STEPS_PER_PAGE = 64;
   localparam int MAX_PAGES      = 4;
   localparam int KEY_SLOTS      = 8;
   localparam int STORE_STEPS    = STEPS_PER_PAGE * MAX_PAGES;

   // CSR indexes, byte address is 4*index
   localparam logic [1:0] REG_CHANNEL = 2'd0;
   localparam logic [1:0] REG_BASE    = 2'd1;
   localparam logic [1:0] REG_HOLD    = 2'd2;
   localparam logic [1:0] REG_PAGES   = 2'd3;

   // codes the block ignores
   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
   localparam logic [1:0] MODE_BAD      = 2'd3;

   // idle cycles after the last expected beat: front reg + 2-deep queue + a
   // worst-case tick in the back end, rounded up
   localparam int DRAIN_CYCLES = 150;
   // cycles with no beat moved on any port before we call it hung
   localparam int QUIET_LIMIT  = 2000;
   // receiver hold-off used to back the block up into req
   localparam int LONG_STALL   = 300;

   localparam rsp_type NO_MSG = '0;

   // one row of the directed plan: a req beat (optionally with hand-typed
   // results) or a CSR write done while the block is idle
   typedef struct packed {
      bit            is_csr;
      logic [1:0]    reg_idx;
      logic [31:0]   reg_val;
      req_type       beat;
      bit            typed;
      logic [1:0]    typed_n;
      rsp_type [0:2] typed_msgs;
   } plan_row_t;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [3:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   always #2 clock = ~clock;

   drum_step_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // ---------------------------------------------------------------------
   // Sequencer mirror: pattern, key modes, hold state, step and config.
   // 2-state so everything starts cleared like the block after reset.
   // ---------------------------------------------------------------------
   bit [KEY_SLOTS-1:0] pat_on      [STORE_STEPS];
   bit [6:0]           pat_vel     [STORE_STEPS][KEY_SLOTS];
   bit [1:0]           key_mode_of [KEY_SLOTS];
   bit                 key_seen    [KEY_SLOTS];
   bit                 key_held    [KEY_SLOTS];
   bit [7:0]           key_age     [KEY_SLOTS];
   bit [7:0]           cur_step;
   bit                 running;

   bit [3:0] cfg_chan  = 4'd0;
   bit [6:0] cfg_base  = 7'd36;
   bit [7:0] cfg_hold  = 8'd1;
   bit [2:0] cfg_pages = 3'd1;

   // MIDI messages still owed by the DUT, oldest first
   rsp_type midi_expected [$];
   rsp_type midi_want;

   int  mismatches   = 0;
   int  msgs_seen    = 0;
   int  beats_sent   = 0;
   int  ticks_played = 0;
   int  toggles      = 0;
   int  mode_writes  = 0;
   int  ignored      = 0;
   int  csr_writes   = 0;
   int  quiet_cycles = 0;
   bit  burst        = 1'b0;   // sender runs back to back
   bit  stall_done   = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // steps the play position wraps over; zero pages pins it to step 0
   function automatic int active_steps();
      if (cfg_pages == 3'd0) return 1;
      if (cfg_pages > 3'(MAX_PAGES)) return STORE_STEPS;
      return int'(cfg_pages) * STEPS_PER_PAGE;
   endfunction

   function automatic rsp_type note_msg(input logic [7:0] kind, input int slot,
                                        input logic [6:0] value);
      rsp_type m;
      m.status_byte = kind + {4'd0, cfg_chan};
      m.note_key    = 7'(cfg_base + slot);
      m.note_value  = value;
      m.last        = 1'b0;
      return m;
   endfunction

   // Apply one accepted req beat to the mirror. On a tick the messages are
   // queued as expectations unless the row carries its own typed results.
   task automatic predict_midi(input req_type b, input bit keep);
      rsp_type msgs [24];
      int      n;
      bit      any_solo;
      bit      plays;
      n = 0;
      case (b.action)
         ACT_TICK: if (running) begin
            ticks_played++;
            any_solo = 1'b0;
            for (int k = 0; k < KEY_SLOTS; k++)
               if (key_mode_of[k] == MODE_SOLO) any_solo = 1'b1;
            // trigger pass: retrigger sends note-off first
            for (int k = 0; k < KEY_SLOTS; k++) begin
               plays = any_solo ? (key_mode_of[k] == MODE_SOLO)
                                : (key_mode_of[k] == MODE_NONE);
               if (pat_on[cur_step][k] && plays) begin
                  if (key_seen[k]) begin
                     msgs[n] = note_msg(NOTE_OFF, k, OFF_VALUE);
                     n++;
                  end
                  msgs[n] = note_msg(NOTE_ON, k, pat_vel[cur_step][k]);
                  n++;
                  key_seen[k] = 1'b1;
                  key_held[k] = 1'b1;
                  key_age[k]  = 8'd0;
               end
            end
            // release pass
            for (int k = 0; k < KEY_SLOTS; k++) begin
               if (key_held[k]) begin
                  if (key_age[k] >= cfg_hold) begin
                     key_held[k] = 1'b0;
                     msgs[n] = note_msg(NOTE_OFF, k, OFF_VALUE);
                     n++;
                  end else begin
                     key_age[k] = key_age[k] + 8'd1;
                  end
               end
            end
            if (int'(cur_step) + 1 >= active_steps()) cur_step = 8'd0;
            else cur_step = cur_step + 8'd1;
            if (n > 0) msgs[n-1].last = 1'b1;
            if (keep)
               for (int i = 0; i < n; i++) midi_expected = {midi_expected, msgs[i]};
         end
         ACT_START: begin
            running  = 1'b1;
            cur_step = 8'd0;
         end
         ACT_STOP: running = 1'b0;
         ACT_TOGGLE: begin
            toggles++;
            if (pat_on[b.cell_req][b.key_index]) begin
               pat_on[b.cell_req][b.key_index] = 1'b0;
            end else begin
               pat_on[b.cell_req][b.key_index]  = 1'b1;
               pat_vel[b.cell_req][b.key_index] = b.velocity;
            end
         end
         ACT_MODE: begin
            mode_writes++;
            if (b.key_mode != MODE_BAD) key_mode_of[b.key_index] = b.key_mode;
         end
         default: ignored++;
      endcase
   endtask

   // Present one beat and hold it until taken; the mirror is updated on the
   // accepting edge so expectations are queued in req order.
   task automatic offer_beat(input req_type b, input bit typed, input int n,
                             input rsp_type [0:2] msgs);
      int gap;
      req_data  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (typed) begin
         for (int i = 0; i < n; i++) midi_expected = {midi_expected, msgs[i]};
         predict_midi(b, 1'b0);
      end else begin
         predict_midi(b, 1'b1);
      end
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Quiet the req side and let the DUT finish, including ticks that emit
   // nothing and are still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (midi_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup, access, then psel is dropped so the next write starts clean
   task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_writes++;
      case (idx)
         REG_CHANNEL: cfg_chan  = val[3:0];
         REG_BASE:    cfg_base  = val[6:0];
         REG_HOLD:    cfg_hold  = val[7:0];
         REG_PAGES:   cfg_pages = val[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type mk(input logic [2:0] a, input logic [7:0] c,
                                  input logic [2:0] k, input logic [6:0] v,
                                  input logic [1:0] m);
      req_type b;
      b.action    = a;
      b.cell_req  = c;
      b.key_index = k;
      b.velocity  = v;
      b.key_mode  = m;
      return b;
   endfunction

   function automatic rsp_type msg(input logic [7:0] s, input logic [6:0] k,
                                   input logic [6:0] v, input logic l);
      rsp_type m;
      m.status_byte = s;
      m.note_key    = k;
      m.note_value  = v;
      m.last        = l;
      return m;
   endfunction

   function automatic plan_row_t row_beat(input req_type b);
      plan_row_t r;
      r      = '0;
      r.beat = b;
      return r;
   endfunction

   function automatic plan_row_t row_typed(input req_type b, input int n, input rsp_type m0,
                                           input rsp_type m1, input rsp_type m2);
      plan_row_t r;
      r            = row_beat(b);
      r.typed      = 1'b1;
      r.typed_n    = 2'(n);
      r.typed_msgs = {m0, m1, m2};
      return r;
   endfunction

   function automatic plan_row_t row_csr(input logic [1:0] idx, input logic [31:0] val);
      plan_row_t r;
      r         = '0;
      r.is_csr  = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   // Random beat. Toggles mostly land just ahead of the play position so
   // ticks actually find notes; the rest is mode churn, transport and noise.
   // Unused fields stay random to walk every input bit.
   function automatic req_type random_beat(input int tick_pct);
      req_type b;
      int      r;
      b = req_type'($urandom);
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
         b.action = ACT_TICK;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            b.action   = ACT_TOGGLE;
            b.cell_req = 8'((int'(cur_step) + $urandom_range(0, 3)) % active_steps());
         end else if (r < 75) begin
            b.action = ACT_MODE;
            r = $urandom_range(0, 9);
            b.key_mode = (r < 6) ? MODE_NONE : (r < 8) ? MODE_MUTE :
                         (r < 9) ? MODE_SOLO : MODE_BAD;
         end else if (r < 85) begin
            b.action = ($urandom_range(0, 2) == 0) ? ACT_STOP : ACT_START;
         end else if (r < 93) begin
            b.action = ACT_TOGGLE;    // anywhere in the store
         end else begin
            b.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
         end
      end
      return b;
   endfunction

   function automatic void report_midi(input string what, input rsp_type want,
                                       input rsp_type got);
      if (mismatches < 10)
         $display("[%0t] %s: status %h/%h key %0d/%0d value %0d/%0d last %0b/%0b (exp/act)",
                  $time, what, want.status_byte, got.status_byte, want.note_key, got.note_key,
                  want.note_value, got.note_value, want.last, got.last);
      mismatches++;
   endfunction

   // ---------------------------------------------------------------------
   // rsp checker: every beat taken is matched against the oldest message owed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         msgs_seen++;
         if (midi_expected.size() == 0) begin
            report_midi("rsp beat with nothing expected", NO_MSG, rsp_data);
         end else begin
            midi_want = midi_expected.pop_front();
            if (midi_want.status_byte !== rsp_data.status_byte ||
                midi_want.note_key    !== rsp_data.note_key    ||
                midi_want.note_value  !== rsp_data.note_value  ||
                midi_want.last        !== rsp_data.last)
               report_midi("rsp field mismatch", midi_want, rsp_data);
         end
      end
   end

   // hang detector: any beat on req, rsp or csr resets the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles, %0d messages still owed",
                  QUIET_LIMIT, midi_expected.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // rsp backpressure: short random stalls with long free-running stretches,
   // plus one long hold-off once traffic is flowing so req backs up
   // ---------------------------------------------------------------------
   initial begin
      int gap;
      int run;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!stall_done && msgs_seen >= 40) begin
            gap        = LONG_STALL;
            stall_done = 1'b1;
         end else begin
            gap = pick_gap();
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 9) < 2) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus: directed plan, then randomized phases with fresh settings
   // ---------------------------------------------------------------------
   initial begin
      plan_row_t   plan [$];
      req_type     b;
      logic [31:0] cfg_vals [4];
      int          counted;
      int          target;
      int          tick_pct;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: channel 0, base key 36, hold 1, one page
      // stopped tick and unknown actions make nothing
      plan = {plan, row_typed(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE), 0,
                              NO_MSG, NO_MSG, NO_MSG)};
      plan = {plan, row_typed(mk(ACT_UNUSED_HI, 8'hFF, 3'd7, 7'h7F, MODE_BAD), 0,
                              NO_MSG, NO_MSG, NO_MSG)};
      plan = {plan, row_typed(mk(ACT_UNUSED_LO, 8'd0, 3'd0, 7'd0, MODE_NONE), 0,
                              NO_MSG, NO_MSG, NO_MSG)};
      plan = {plan, row_beat(mk(ACT_START, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_TOGGLE, 8'd0, 3'd0, 7'd100, MODE_NONE))};
      // first hit: note-on only, held one step
      plan = {plan, row_typed(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE), 1,
                              msg(NOTE_ON, 7'd36, 7'd100, 1'b1), NO_MSG, NO_MSG)};
      // empty step: the hold runs out
      plan = {plan, row_typed(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE), 1,
                              msg(NOTE_OFF, 7'd36, OFF_VALUE, 1'b1), NO_MSG, NO_MSG)};
      // zero hold: retrigger off, on, and release in the same tick
      plan = {plan, row_csr(REG_HOLD, 32'd0)};
      plan = {plan, row_beat(mk(ACT_START, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      plan = {plan, row_typed(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE), 3,
                              msg(NOTE_OFF, 7'd36, OFF_VALUE, 1'b0),
                              msg(NOTE_ON, 7'd36, 7'd100, 1'b0),
                              msg(NOTE_OFF, 7'd36, OFF_VALUE, 1'b1))};
      // top channel, top legal base key, last key slot, muted slot 0
      plan = {plan, row_csr(REG_CHANNEL, 32'd15)};
      plan = {plan, row_csr(REG_BASE, 32'd120)};
      plan = {plan, row_beat(mk(ACT_TOGGLE, 8'd255, 3'd7, 7'd127, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_TOGGLE, 8'd0, 3'd7, 7'd0, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_MODE, 8'd0, 3'd3, 7'd0, MODE_BAD))};
      plan = {plan, row_beat(mk(ACT_MODE, 8'd0, 3'd0, 7'd0, MODE_MUTE))};
      plan = {plan, row_beat(mk(ACT_START, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      plan = {plan, row_typed(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE), 2,
                              msg(NOTE_ON | 8'h0F, 7'd127, 7'd0, 1'b0),
                              msg(NOTE_OFF | 8'h0F, 7'd127, OFF_VALUE, 1'b1), NO_MSG)};
      // solo gating, key number wrap, zero pages, longest hold
      plan = {plan, row_beat(mk(ACT_MODE, 8'd0, 3'd7, 7'd0, MODE_SOLO))};
      plan = {plan, row_csr(REG_BASE, 32'd127)};
      plan = {plan, row_csr(REG_PAGES, 32'd0)};
      plan = {plan, row_csr(REG_HOLD, 32'd255)};
      plan = {plan, row_beat(mk(ACT_START, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_TOGGLE, 8'd0, 3'd7, 7'd0, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_MODE, 8'd0, 3'd7, 7'd0, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_MODE, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      // pages above the store saturate
      plan = {plan, row_csr(REG_PAGES, 32'd7)};
      plan = {plan, row_beat(mk(ACT_TOGGLE, 8'd200, 3'd3, 7'd1, MODE_NONE))};
      plan = {plan, row_beat(mk(ACT_STOP, 8'd0, 3'd0, 7'd0, MODE_NONE))};
      plan = {plan, row_typed(mk(ACT_TICK, 8'd0, 3'd0, 7'd0, MODE_NONE), 0,
                              NO_MSG, NO_MSG, NO_MSG)};

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            reg_write(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            offer_beat(plan[i].beat, plan[i].typed, int'(plan[i].typed_n),
                       plan[i].typed_msgs);
         end
      end

      // Random phases. Phase 0 is tick-heavy on one page so the step wraps;
      // phase 1 pins the other register extremes; the rest are random.
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: cfg_vals = '{32'd0, 32'd0, 32'd0, 32'd1};
            1: cfg_vals = '{32'd15, 32'd127, 32'd255, 32'd4};
            default: begin
               cfg_vals[0] = $urandom_range(0, 15);
               cfg_vals[1] = $urandom_range(0, 127);
               cfg_vals[2] = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                        : $urandom_range(0, 255);
               cfg_vals[3] = $urandom_range(0, 7);
            end
         endcase
         for (int i = 0; i < 4; i++) reg_write(2'(i), cfg_vals[i]);
         burst    = ($urandom_range(0, 2) == 0);
         tick_pct = (ph == 0) ? 88 : 50;
         target   = (ph == 0) ? 80 : 35;
         b = req_type'($urandom);
         b.action = ACT_START;
         offer_beat(b, 1'b0, 0, '0);
         counted = 1;
         while (counted < target) begin
            b = random_beat(tick_pct);
            offer_beat(b, 1'b0, 0, '0);
            if (b.action <= ACT_MODE) counted++;
         end
      end
      burst = 1'b0;

      settle();
      $display("covered %0d req beats: %0d ticks while playing, %0d toggles,",
               beats_sent, ticks_played, toggles);
      $display("  %0d mode writes, %0d ignored; checked %0d MIDI messages over %0d csr writes",
               mode_writes, ignored, msgs_seen, csr_writes);
      if (mismatches == 0 && midi_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/drs_pkg.sv
sv/drs_front.sv
sv/drs_fifo.sv
sv/drs_back.sv
sv/drum_step_sequencer.sv
tb/sv/drum_step_sequencer_tb.sv
